[hw/rtl/smrt_pkg.sv]
// Shared types and constants for the simplex minimum ratio test block.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none

package smrt_pkg;

   localparam int DATA_W    = 32;
   localparam int IDX_W     = 10;
   localparam int THR_W     = 31;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_DIR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MU            = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_PARTNER   = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef struct packed {
      logic signed [DATA_W-1:0] direction;
      logic [IDX_W-1:0]         var_index;
      logic signed [DATA_W-1:0] var_value;
      logic signed [DATA_W-1:0] partner_value;
      logic                     last_entry;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] best_index;
   } rsp_type;

   typedef struct packed {
      logic [THR_W-1:0]         dir_threshold;
      logic signed [DATA_W-1:0] mu;
      logic                     use_partner;
   } cfg_type;

   typedef struct packed {
      logic                     counted;
      logic                     last_entry;
      logic signed [DATA_W-1:0] numerator;
      logic signed [DATA_W-1:0] direction;
      logic [IDX_W-1:0]         var_index;
   } entry_type;

endpackage

`default_nettype wire

[hw/rtl/smrt_front.sv]
// Front end: accepts requests, checks threshold and index range, forms the
// saturated numerator. Depends on smrt_pkg.
`default_nettype none

module smrt_front #(
   parameter int NUM_VARS = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire smrt_pkg::cfg_type    cfg,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire smrt_pkg::req_type    req_data,
   output logic                      push_valid,
   input  wire logic                 push_ready,
   output smrt_pkg::entry_type       push_data
);

   logic                                   s1_valid_ff, s1_valid_in;
   logic signed [smrt_pkg::DATA_W-1:0]     s1_dir_ff, s1_dir_in;
   logic [smrt_pkg::IDX_W-1:0]             s1_idx_ff, s1_idx_in;
   logic signed [smrt_pkg::DATA_W-1:0]     s1_val_ff, s1_val_in;
   logic signed [smrt_pkg::PROD_W-1:0]     s1_prod_ff, s1_prod_in;
   logic                                   s1_counted_ff, s1_counted_in;
   logic                                   s1_last_ff, s1_last_in;

   logic                                   accept;
   logic                                   dir_ok;
   logic                                   idx_ok;
   logic signed [smrt_pkg::PROD_W-1:0]     product;
   logic signed [48:0]                     sum;
   logic signed [smrt_pkg::DATA_W-1:0]     numerator;

   assign req_ready = !s1_valid_ff || push_ready;
   assign accept    = req_valid && req_ready;

   assign dir_ok  = $signed(req_data.direction) > $signed({1'b0, cfg.dir_threshold});
   assign idx_ok  = 32'(req_data.var_index) < NUM_VARS;
   assign product = $signed(cfg.mu) * $signed(req_data.partner_value);

   always_comb begin
      s1_dir_in     = req_data.direction;
      s1_idx_in     = req_data.var_index;
      s1_val_in     = req_data.var_value;
      s1_prod_in    = cfg.use_partner ? product : '0;
      s1_counted_in = dir_ok && idx_ok;
      s1_last_in    = req_data.last_entry;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_dir_ff     <= s1_dir_in;
         s1_idx_ff     <= s1_idx_in;
         s1_val_ff     <= s1_val_in;
         s1_prod_ff    <= s1_prod_in;
         s1_counted_ff <= s1_counted_in;
         s1_last_ff    <= s1_last_in;
      end
   end

   // floor of product / 2^16, then saturate the sum to 32 bits
   assign sum = 49'(s1_val_ff) + 49'(s1_prod_ff >>> 16);

   always_comb begin
      if ((&sum[48:31]) || !(|sum[48:31])) begin
         numerator = sum[31:0];
      end else if (sum[48]) begin
         numerator = 32'sh8000_0000;
      end else begin
         numerator = 32'sh7fff_ffff;
      end
   end

   always_comb begin
      push_valid           = s1_valid_ff;
      push_data.counted    = s1_counted_ff;
      push_data.last_entry = s1_last_ff;
      push_data.numerator  = numerator;
      push_data.direction  = s1_dir_ff;
      push_data.var_index  = s1_idx_ff;
   end

endmodule

`default_nettype wire

[hw/rtl/smrt_fifo.sv]
// Short queue of classified entries between front and back end.
// Depends on smrt_pkg.
`default_nettype none

module smrt_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire smrt_pkg::entry_type  push_data,
   input  wire logic                 pop,
   output logic                      empty,
   output smrt_pkg::entry_type       head
);

   smrt_pkg::entry_type               entries_ff [smrt_pkg::QUEUE_DEPTH];
   logic [smrt_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [smrt_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [smrt_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              push;

   assign push_ready = count_ff < smrt_pkg::QCNT_W'(smrt_pkg::QUEUE_DEPTH);
   assign empty      = count_ff == '0;
   assign head       = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/smrt_back.sv]
// Back end: cross-multiplies each counted entry against the kept best,
// keeps the minimum ratio and registers the response. Depends on smrt_pkg.
`default_nettype none

module smrt_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 empty,
   input  wire smrt_pkg::entry_type  head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output smrt_pkg::rsp_type         rsp_data
);

   localparam logic S_MUL = 1'b0;
   localparam logic S_CMP = 1'b1;

   logic                                state_ff, state_in;
   smrt_pkg::entry_type                 cur_ff, cur_in;
   logic signed [smrt_pkg::PROD_W-1:0]  prod_a_ff, prod_a_in;
   logic signed [smrt_pkg::PROD_W-1:0]  prod_b_ff, prod_b_in;
   logic                                have_best_ff, have_best_in;
   logic signed [smrt_pkg::DATA_W-1:0]  best_num_ff, best_num_in;
   logic signed [smrt_pkg::DATA_W-1:0]  best_dir_ff, best_dir_in;
   logic [smrt_pkg::IDX_W-1:0]          best_var_ff, best_var_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   smrt_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   logic                                take;
   logic                                out_free;
   logic                                advance;
   logic                                hb_next;
   logic [smrt_pkg::IDX_W-1:0]          var_next;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = (state_ff == S_MUL) && !empty;
   assign take     = cur_ff.counted && (!have_best_ff || (prod_a_ff < prod_b_ff));
   assign advance  = (state_ff == S_CMP) && (!cur_ff.last_entry || out_free);
   assign hb_next  = have_best_ff || take;
   assign var_next = take ? cur_ff.var_index : best_var_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      have_best_in = have_best_ff;
      best_num_in  = best_num_ff;
      best_dir_in  = best_dir_ff;
      best_var_in  = best_var_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_MUL: begin
            if (pop) begin
               cur_in    = head;
               prod_a_in = head.numerator * best_dir_ff;
               prod_b_in = best_num_ff * head.direction;
               state_in  = S_CMP;
            end
         end
         S_CMP: begin
            if (advance) begin
               state_in = S_MUL;
               if (take) begin
                  best_num_in = cur_ff.numerator;
                  best_dir_in = cur_ff.direction;
                  best_var_in = cur_ff.var_index;
               end
               if (cur_ff.last_entry) begin
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.found      = hb_next;
                  rsp_data_in.best_index = hb_next ? var_next : '0;
                  have_best_in           = 1'b0;
               end else begin
                  have_best_in = hb_next;
               end
            end
         end
         default: begin
            state_in = S_MUL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_MUL;
         have_best_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_best_ff <= have_best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      prod_a_ff   <= prod_a_in;
      prod_b_ff   <= prod_b_in;
      best_num_ff <= best_num_in;
      best_dir_ff <= best_dir_in;
      best_var_ff <= best_var_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_pop_only_when_ready: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == S_MUL) && !empty)
      else $error("entry popped outside multiply step or from empty queue");

   a_best_dir_positive: assert property (@(posedge clock) disable iff (reset)
      have_best_ff |-> (best_dir_ff > 0))
      else $error("kept best has non-positive direction");

   a_last_emits_and_clears: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_CMP) && cur_ff.last_entry && out_free)
      |=> rsp_valid_ff && !have_best_ff && (state_ff == S_MUL))
      else $error("last entry did not produce response and clear");

   a_found_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.found) |-> (rsp_data_ff.best_index == '0))
      else $error("nonzero index without found");
`endif

endmodule

`default_nettype wire

[hw/rtl/simplex_min_ratio_test_top.sv]
// Top level of the simplex minimum ratio test block: configuration registers,
// front end, entry queue and back end. Depends on smrt_pkg and all smrt_ modules.
`default_nettype none

// Each request is one nonzero entry of a sparse step direction. The front end
// takes one request per cycle unless the full two-entry queue holds it back, and
// forms the numerator from the registered request; the back end handles each
// entry in a multiply step (two 32x32 cross multiplications against the kept
// best) and then a compare and update step, and takes no new entry until it is
// through with the last one. A response is produced only for a request marked
// last_entry, after the front-end register, the queue and the back end's
// multiply and compare steps, and is held in an output register until taken;
// the kept state is then cleared for the next vector. Configuration is to be
// written through the csr_ port only while no request is in flight; the block does not enforce it.
module simplex_min_ratio_test_top #(
   parameter int NUM_VARS = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire smrt_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output smrt_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_write_en,
   input  wire logic [smrt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [smrt_pkg::DATA_W-1:0]        csr_wdata
);

   smrt_pkg::cfg_type     cfg_ff, cfg_in;
   logic                  push_valid;
   logic                  push_ready;
   smrt_pkg::entry_type   push_data;
   logic                  pop;
   logic                  empty;
   smrt_pkg::entry_type   head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            smrt_pkg::CSR_DIR_THRESHOLD: cfg_in.dir_threshold = csr_wdata[smrt_pkg::THR_W-1:0];
            smrt_pkg::CSR_MU:            cfg_in.mu            = csr_wdata;
            smrt_pkg::CSR_USE_PARTNER:   cfg_in.use_partner   = csr_wdata[0];
            default:                     cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dir_threshold <= smrt_pkg::THR_W'(1);
         cfg_ff.mu            <= '0;
         cfg_ff.use_partner   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   smrt_front #(
      .NUM_VARS (NUM_VARS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   smrt_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop        (pop),
      .empty      (empty),
      .head       (head)
   );

   smrt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[test/smrt_ratio_checker.sv]
`timescale 1ns / 100ps
// Response checker for the simplex minimum ratio test block: tracks csr_ writes,
// predicts the winning index of every vector and compares each response.
// Depends on smrt_pkg.
module smrt_ratio_checker #(
   parameter int NUM_VARS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  smrt_pkg::req_type                 req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  smrt_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write_en,
   input  logic [smrt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [smrt_pkg::DATA_W-1:0]       csr_wdata,
   output int                                mismatches,
   output int                                outstanding
);
   import smrt_pkg::*;

   localparam longint NUM_MAX = (64'sd1 <<< 31) - 1;
   localparam longint NUM_MIN = -(64'sd1 <<< 31);

   logic [THR_W-1:0]         threshold;
   logic signed [DATA_W-1:0] mu;
   logic                     use_partner;

   logic                     have_best;
   longint                   best_num;
   longint                   best_dir;
   logic [IDX_W-1:0]         best_var;

   rsp_type                  expected_winners[$];
   int                       response_no;

   function automatic longint ratio_numerator(req_type r);
      longint num;
      longint prod;
      num = longint'($signed(r.var_value));
      if (use_partner) begin
         prod = longint'(mu) * longint'($signed(r.partner_value));
         num += prod >>> 16;
      end
      if (num > NUM_MAX) num = NUM_MAX;
      if (num < NUM_MIN) num = NUM_MIN;
      return num;
   endfunction

   task automatic clear_vector();
      have_best = 1'b0;
      best_num  = 0;
      best_dir  = 0;
      best_var  = '0;
   endtask

   task automatic fold_entry(req_type r);
      longint  dir;
      longint  num;
      rsp_type w;
      dir = longint'($signed(r.direction));
      if (dir > longint'(threshold) && int'(r.var_index) < NUM_VARS) begin
         num = ratio_numerator(r);
         // cross-multiplied ratio compare, both directions positive
         if (!have_best || num * best_dir < best_num * dir) begin
            have_best = 1'b1;
            best_num  = num;
            best_dir  = dir;
            best_var  = r.var_index;
         end
      end
      if (r.last_entry) begin
         w.found      = have_best;
         w.best_index = have_best ? best_var : '0;
         expected_winners.push_back(w);
         clear_vector();
      end
   endtask

   task automatic report(string what, logic [IDX_W-1:0] got_v, logic [IDX_W-1:0] want_v);
      $display("response %0d: %s got %0d expected %0d", response_no, what, got_v, want_v);
      mismatches++;
   endtask

   task automatic check_winner(rsp_type got);
      rsp_type want;
      if (expected_winners.size() == 0) begin
         report("response with no vector pending, best_index", got.best_index, '0);
      end else begin
         want = expected_winners.pop_front();
         if (got.found !== want.found)
            report("found", IDX_W'(got.found), IDX_W'(want.found));
         if (got.best_index !== want.best_index)
            report("best_index", got.best_index, want.best_index);
      end
      response_no++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         threshold   = 1;
         mu          = '0;
         use_partner = 1'b1;
         clear_vector();
         expected_winners.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_DIR_THRESHOLD: threshold   = csr_wdata[THR_W-1:0];
               CSR_MU:            mu          = csr_wdata;
               CSR_USE_PARTNER:   use_partner = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) check_winner(rsp_data);
         if (req_valid && req_ready) fold_entry(req_data);
      end
      outstanding = expected_winners.size();
   end

endmodule

[test/simplex_min_ratio_test_top_tb.sv]
`timescale 1ns / 100ps
// Testbench top for simplex_min_ratio_test_top: clock, reset, request stimulus
// over several register settings, response stalls and the verdict.
// Depends on smrt_pkg, simplex_min_ratio_test_top and smrt_ratio_checker.
module simplex_min_ratio_test_top_tb;
   import smrt_pkg::*;

   localparam int NUM_VARS     = 1024;
   localparam int RANDOM_ITEMS = 400;
   localparam int PHASES       = 6;
   localparam int SETTLE       = 8;
   localparam int CYCLE_LIMIT  = 200000;

   typedef enum logic [1:0] {READY_ALWAYS, READY_HALF, READY_SPARSE} stall_kind_type;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_ready;
   req_type              req_data     = '0;
   logic                 rsp_valid;
   logic                 rsp_ready    = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [DATA_W-1:0]    csr_wdata    = '0;

   int                   mismatches;
   int                   outstanding;
   int unsigned          cycles       = 0;
   int                   burst_left   = 0;
   int                   sent         = 0;
   logic [THR_W-1:0]     cur_thr      = 1;
   stall_kind_type       stall_mode   = READY_ALWAYS;

   simplex_min_ratio_test_top #(.NUM_VARS(NUM_VARS)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   smrt_ratio_checker #(.NUM_VARS(NUM_VARS)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .outstanding  (outstanding)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("simplex_min_ratio_test_top verification failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= stall_kind_type'($urandom_range(0, 2));
      case (stall_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
         default:      rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   function automatic req_type entry(logic signed [DATA_W-1:0] dir, int idx,
                                     logic signed [DATA_W-1:0] val,
                                     logic signed [DATA_W-1:0] par, logic last);
      req_type r;
      r.direction     = dir;
      r.var_index     = IDX_W'(idx);
      r.var_value     = val;
      r.partner_value = par;
      r.last_entry    = last;
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] random_value();
      case ($urandom_range(0, 5))
         0:       return 32'h7fffffff;
         1:       return 32'h80000000;
         2, 3:    return DATA_W'($urandom_range(0, 1 << 21)) - (1 << 20);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_entry();
      req_type r;
      longint  d;
      case ($urandom_range(0, 6))
         0:       d = longint'($signed(32'($urandom)));
         1:       d = -longint'($urandom_range(0, 1 << 20));
         2:       d = longint'(cur_thr) + $urandom_range(0, 1);
         3:       d = $urandom_range(1, 1 << 20);
         default: d = longint'(cur_thr) + $urandom_range(1, 1 << 18);
      endcase
      if (d > 64'sh7fffffff) d = 64'sh7fffffff;
      r.direction     = d[DATA_W-1:0];
      r.var_index     = IDX_W'($urandom);
      r.var_value     = random_value();
      r.partner_value = random_value();
      r.last_entry    = 1'b0;
      return r;
   endfunction

   // ready only moves at the rising edge, so its value at the falling edge
   // holds for the next rising edge
   task automatic send(req_type r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_config(logic [THR_W-1:0] thr, logic signed [DATA_W-1:0] m, logic up);
      cur_thr = thr;
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_DIR_THRESHOLD;
      csr_wdata    <= {1'($urandom_range(0, 1)), thr};
      @(negedge clock);
      csr_index    <= CSR_MU;
      csr_wdata    <= m;
      @(negedge clock);
      csr_index    <= CSR_USE_PARTNER;
      csr_wdata    <= {31'($urandom), up};
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic random_vector(int n);
      req_type r;
      req_type prev;
      for (int k = 0; k < n; k++) begin
         r = random_entry();
         // repeat an earlier entry's ratio to provoke a tie
         if (k > 0 && $urandom_range(0, 5) == 0) begin
            r.direction     = prev.direction;
            r.var_value     = prev.var_value;
            r.partner_value = prev.partner_value;
         end
         r.last_entry = (k == n - 1);
         send(r);
         prev = r;
         sent++;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: threshold one ulp, mu zero so the partner term is zero
      send(entry(2, 5, 10, 0, 1'b1));
      send(entry(1, 7, 100, 0, 1'b0));
      send(entry(0, 8, -100, 0, 1'b0));
      send(entry(32'sh80000000, 9, 0, 0, 1'b1));
      send(entry(32'sh10000, 1023, 32'sh7fffffff, 0, 1'b0));
      send(entry(32'sh7fffffff, 0, 32'sh80000000, 0, 1'b0));
      send(entry(32'sh10000, 300, 0, 0, 1'b1));
      send(entry(32'sh20000, 11, 32'sh40000, 32'sh7fffffff, 1'b0));
      send(entry(32'sh10000, 12, 32'sh20000, 32'sh80000000, 1'b0));
      send(entry(32'sh40000, 13, 32'sh80000, 0, 1'b1));
      send(entry(3, 20, -5, 0, 1'b0));
      send(entry(7, 21, -12, 0, 1'b1));
      drain();

      // saturation of the numerator both ways
      set_config('0, 32'sh7fffffff, 1'b1);
      send(entry(1, 40, 32'sh7fffffff, 32'sh7fffffff, 1'b0));
      send(entry(1, 41, 32'sh80000000, 32'sh80000000, 1'b0));
      send(entry(0, 42, 32'sh80000000, 0, 1'b1));
      drain();

      // nothing can pass the largest threshold
      set_config(31'h7fffffff, 32'sh80000000, 1'b0);
      send(entry(32'sh7fffffff, 1023, 32'sh80000000, 32'sh7fffffff, 1'b1));
      drain();

      // product rounds toward minus infinity
      set_config(1, -1, 1'b1);
      send(entry(32'sh10000, 51, 0, 0, 1'b0));
      send(entry(32'sh10000, 50, 0, 1, 1'b1));
      drain();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: set_config(31'($urandom_range(0, 1 << 17)), $urandom, 1'b1);
            1: set_config('0, '0, 1'b0);
            2: set_config(31'h7fffffff, 32'sh7fffffff, 1'b1);
            3: set_config(31'($urandom), $urandom, 1'($urandom_range(0, 1)));
            4: set_config(31'($urandom_range(0, 1 << 16)), 32'sh80000000, 1'b1);
            default: set_config(31'($urandom_range(0, 1 << 20)), $urandom, 1'b1);
         endcase
         while (sent < (p + 1) * RANDOM_ITEMS / PHASES) begin
            if ($urandom_range(0, 9) == 0)
               random_vector($urandom_range(7, 20));
            else
               random_vector($urandom_range(1, 6));
            if ($urandom_range(0, 19) == 0) drain();
         end
         drain();
      end

      if (mismatches == 0)
         $display("simplex_min_ratio_test_top verification clean");
      else
         $display("simplex_min_ratio_test_top verification failed");
      $finish;
   end

endmodule
